/* sv/humidity_sensor_response_encoder_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the humidity sensor response encoder
// Clocked on clk; every check is switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_RESPONSE_ENCODER_ASSERT_SVH
`define HUMIDITY_SENSOR_RESPONSE_ENCODER_ASSERT_SVH

// Same-cycle check: cond must hold at every active edge
`define HSRE_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Next-cycle check: ante must be followed by cons
`define HSRE_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hsre_pkg.sv */
// ---------------------------------------------------------------------------
// hsre_pkg
// Shared types, constants and CRC function of the sensor response encoder.
// ---------------------------------------------------------------------------
package hsre_pkg;

  // Command codes
  localparam logic [7:0] OP_SINGLE = 8'h24;
  localparam logic [7:0] OP_FETCH  = 8'h E0;
  localparam logic [7:0] OP_SERIAL = 8'h36;
  localparam logic [7:0] FETCH_ARG = 8'h00;

  // Minimum command length for the fetch check
  localparam logic [2:0] FETCH_MIN_LEN = 3'd2;
  localparam logic [2:0] RESP_LEN_NONE = 3'd0;
  localparam logic [2:0] RESP_LEN_FULL = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LOW  = 1'b1;
  localparam logic [15:0] SERIAL_HIGH_RST = 16'hDEAD;
  localparam logic [15:0] SERIAL_LOW_RST  = 16'hBEEF;

  // CRC-8 parameters
  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [7:0] CRC_START = 8'hFF;

  // Scaling: raw = x * FULL_SCALE / SPAN, done as (x * RECIP) >> RECIP_SHIFT.
  // The reciprocal is rounded up; with x at most SPAN the error stays below
  // 1/SPAN, so the truncated product equals the exact quotient.
  localparam int unsigned FULL_SCALE  = 65535;
  localparam int unsigned T_OFFSET    = 450;
  localparam int unsigned T_SPAN      = 1750;
  localparam int unsigned H_SPAN      = 1000;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [27:0] TEMP_RECIP = 28'((64'(FULL_SCALE) * (64'd1 << RECIP_SHIFT)
                                            + 64'(T_SPAN) - 64'd1) / 64'(T_SPAN));
  localparam logic [28:0] HUM_RECIP  = 29'((64'(FULL_SCALE) * (64'd1 << RECIP_SHIFT)
                                            + 64'(H_SPAN) - 64'd1) / 64'(H_SPAN));

  // Result of one command
  typedef struct packed {
    logic       accepted;
    logic [2:0] response_length;
    logic [7:0] resp_byte_0;
    logic [7:0] resp_byte_1;
    logic [7:0] resp_byte_2;
    logic [7:0] resp_byte_3;
    logic [7:0] resp_byte_4;
    logic [7:0] resp_byte_5;
  } resp_t;

  // CRC-8 over the two bytes of a word, most significant byte first
  function automatic logic [7:0] crc8_word(input logic [15:0] word);
    logic [7:0] crc;
    crc = CRC_START ^ word[15:8];
    for (int k = 0; k < 8; k++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    crc = crc ^ word[7:0];
    for (int k = 0; k < 8; k++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

endpackage

/* sv/hsre_cmd_if.sv */
// ---------------------------------------------------------------------------
// hsre_cmd_if
// Command channel: command bytes plus current temperature and humidity.
// ---------------------------------------------------------------------------
interface hsre_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd_length;
  logic [7:0]        cmd_first;
  logic [7:0]        cmd_second;
  logic signed [11:0] temp_tenths;
  logic [9:0]        humid_tenths;

  modport source (output valid, cmd_length, cmd_first, cmd_second, temp_tenths,
                  humid_tenths, input ready);
  modport sink   (input valid, cmd_length, cmd_first, cmd_second, temp_tenths,
                  humid_tenths, output ready);
endinterface

/* sv/hsre_resp_if.sv */
// ---------------------------------------------------------------------------
// hsre_resp_if
// Response channel: accept flag, response length and six response bytes.
// ---------------------------------------------------------------------------
interface hsre_resp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] response_length;
  logic [7:0] resp_byte_0;
  logic [7:0] resp_byte_1;
  logic [7:0] resp_byte_2;
  logic [7:0] resp_byte_3;
  logic [7:0] resp_byte_4;
  logic [7:0] resp_byte_5;

  modport source (output valid, accepted, response_length, resp_byte_0, resp_byte_1,
                  resp_byte_2, resp_byte_3, resp_byte_4, resp_byte_5, input ready);
  modport sink   (input valid, accepted, response_length, resp_byte_0, resp_byte_1,
                  resp_byte_2, resp_byte_3, resp_byte_4, resp_byte_5, output ready);
endinterface

/* sv/humidity_sensor_response_encoder.sv */
// ---------------------------------------------------------------------------
// humidity_sensor_response_encoder
// Command-response encoder of an I2C temperature and humidity sensor.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            contents
//  in_cmd    sink       valid/ready          command length, two bytes, T, RH
//  out_rsp   source     valid/ready          accept flag, length, six bytes
//  cfg_*     write      cfg_we               serial word high / low
//
//  One transaction per cycle sustained while out_rsp is ready (input register,
//  then result register after the scaling multiply and CRC tree).
//  Reset (rst_n low, synchronous) empties both registers and restores the
//  serial words. A stall on out_rsp holds the result and lets one further
//  transaction sit in the input register before in_cmd.ready drops.
// ---------------------------------------------------------------------------
module humidity_sensor_response_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  hsre_cmd_if.sink                      in_cmd,
  hsre_resp_if.source                   out_rsp,
  input  logic                          cfg_we,
  input  logic [hsre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);
  import hsre_pkg::*;

  logic               s1_valid_r;
  logic [2:0]         s1_length_r;
  logic [7:0]         s1_first_r;
  logic [7:0]         s1_second_r;
  logic signed [11:0] s1_temp_r;
  logic [9:0]         s1_humid_r;
  logic               s1_advance;
  logic               out_valid_r;
  resp_t              out_resp_r;
  resp_t              calc_resp;
  logic [15:0]        serial_high_r;
  logic [15:0]        serial_low_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_high_r <= SERIAL_HIGH_RST;
      serial_low_r  <= SERIAL_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERIAL_HIGH: serial_high_r <= cfg_wdata;
        CFG_SERIAL_LOW:  serial_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control: stage 1 moves on when the result register is empty or being taken
  assign s1_advance   = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_cmd.ready = !s1_valid_r || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_cmd.ready) begin
      s1_valid_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_cmd.valid && in_cmd.ready) begin
      s1_length_r <= in_cmd.cmd_length;
      s1_first_r  <= in_cmd.cmd_first;
      s1_second_r <= in_cmd.cmd_second;
      s1_temp_r   <= in_cmd.temp_tenths;
      s1_humid_r  <= in_cmd.humid_tenths;
    end
  end

  hsre_resp_calc u_calc (
    .cmd_length   (s1_length_r),
    .cmd_first    (s1_first_r),
    .cmd_second   (s1_second_r),
    .temp_tenths  (s1_temp_r),
    .humid_tenths (s1_humid_r),
    .serial_high  (serial_high_r),
    .serial_low   (serial_low_r),
    .resp         (calc_resp)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_resp_r <= calc_resp;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.accepted        = out_resp_r.accepted;
  assign out_rsp.response_length = out_resp_r.response_length;
  assign out_rsp.resp_byte_0     = out_resp_r.resp_byte_0;
  assign out_rsp.resp_byte_1     = out_resp_r.resp_byte_1;
  assign out_rsp.resp_byte_2     = out_resp_r.resp_byte_2;
  assign out_rsp.resp_byte_3     = out_resp_r.resp_byte_3;
  assign out_rsp.resp_byte_4     = out_resp_r.resp_byte_4;
  assign out_rsp.resp_byte_5     = out_resp_r.resp_byte_5;

  // Checks
`include "humidity_sensor_response_encoder_assert.svh"

  `HSRE_CHECK(a_rejected_empty, !(out_valid_r && !out_resp_r.accepted) || (out_resp_r.response_length == RESP_LEN_NONE), "rejected command carries response bytes")
  `HSRE_CHECK(a_len_legal, !out_valid_r || out_resp_r.response_length == RESP_LEN_NONE || out_resp_r.response_length == RESP_LEN_FULL, "illegal response length")
  `HSRE_CHECK_NXT(a_stage_moves, s1_valid_r && !out_valid_r, out_valid_r, "held transaction did not reach result register")
  `HSRE_CHECK_NXT(a_cfg_high, cfg_we && cfg_index == CFG_SERIAL_HIGH, serial_high_r == $past(cfg_wdata), "serial word high not written")

endmodule

/* sv/hsre_resp_calc.sv */
// ---------------------------------------------------------------------------
// hsre_resp_calc
// Decode one command and build its response: scaled readings or serial words.
// ---------------------------------------------------------------------------
module hsre_resp_calc (
  input  logic [2:0]         cmd_length,
  input  logic [7:0]         cmd_first,
  input  logic [7:0]         cmd_second,
  input  logic signed [11:0] temp_tenths,
  input  logic [9:0]         humid_tenths,
  input  logic [15:0]        serial_high,
  input  logic [15:0]        serial_low,
  output hsre_pkg::resp_t    resp
);
  import hsre_pkg::*;

  logic signed [12:0] temp_shifted;
  logic [38:0]        temp_prod;
  logic [38:0]        hum_prod;
  logic [15:0]        temp_raw;
  logic [15:0]        hum_raw;
  logic               is_meas;
  logic               is_serial;
  logic [15:0]        word_a;
  logic [15:0]        word_b;

  // Offset temperature to a non-negative span
  assign temp_shifted = 13'(temp_tenths) + 13'(T_OFFSET);
  assign temp_prod    = 39'(temp_shifted[10:0]) * 39'(TEMP_RECIP);
  assign hum_prod     = 39'(humid_tenths) * 39'(HUM_RECIP);

  // Saturate below zero and above full span
  always_comb begin
    if (temp_shifted <= 13'sd0) begin
      temp_raw = '0;
    end else if (temp_shifted > 13'(T_SPAN)) begin
      temp_raw = 16'(FULL_SCALE);
    end else begin
      temp_raw = temp_prod[RECIP_SHIFT +: 16];
    end
    if (humid_tenths > 10'(H_SPAN)) begin
      hum_raw = 16'(FULL_SCALE);
    end else begin
      hum_raw = hum_prod[RECIP_SHIFT +: 16];
    end
  end

  // Decode command; periodic start, soft reset and unknown codes give no data
  assign is_meas   = (cmd_first == OP_SINGLE) ||
                     (cmd_first == OP_FETCH && cmd_length >= FETCH_MIN_LEN &&
                      cmd_second == FETCH_ARG);
  assign is_serial = (cmd_first == OP_SERIAL);
  assign word_a    = is_meas ? temp_raw : serial_high;
  assign word_b    = is_meas ? hum_raw  : serial_low;

  // Assemble response; empty command is rejected with all zeros
  always_comb begin
    resp = '0;
    if (cmd_length != 3'd0) begin
      resp.accepted = 1'b1;
      if (is_meas || is_serial) begin
        resp.response_length = RESP_LEN_FULL;
        resp.resp_byte_0     = word_a[15:8];
        resp.resp_byte_1     = word_a[7:0];
        resp.resp_byte_2     = crc8_word(word_a);
        resp.resp_byte_3     = word_b[15:8];
        resp.resp_byte_4     = word_b[7:0];
        resp.resp_byte_5     = crc8_word(word_b);
      end
    end
  end

endmodule
